// File: rtl/sptx_pkg.sv
// shared types and constants for the slip packet framer transmit core
package sptx_pkg;

  localparam int MAX_PAYLOAD_DEFAULT = 252;
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_DATA  = 1'b1;

  localparam logic [7:0] SLIP_END     = 8'hC0;
  localparam logic [7:0] SLIP_ESC     = 8'hDB;
  localparam logic [7:0] SLIP_ESC_END = 8'hDC;
  localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;

  typedef enum logic [1:0] {
    JOB_ERR,
    JOB_START,
    JOB_DATA
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [7:0]  body;
    logic        tail;
    logic [7:0]  flags;
    logic [7:0]  sum;
  } job_t;

  typedef enum logic [2:0] {
    PH_ERR,
    PH_END0,
    PH_BODY,
    PH_FLAGS,
    PH_SUM,
    PH_END1
  } phase_t;

endpackage

// File: rtl/sptx_if.sv
// item channel interfaces for the framer input and the line output
interface sptx_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] data_byte;
  logic [7:0] payload_length;
  logic [7:0] flags_byte;

  modport source (output valid, command, data_byte, payload_length, flags_byte,
                  input ready);
  modport sink (input valid, command, data_byte, payload_length, flags_byte,
                output ready);
endinterface

interface sptx_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       error;

  modport source (output valid, out_byte, run_last, error, input ready);
  modport sink (input valid, out_byte, run_last, error, output ready);
endinterface

// File: rtl/sptx_front.sv
// front part: accepts items, tracks the open packet and issues jobs
module sptx_front #(
  parameter int MAX_PAYLOAD = sptx_pkg::MAX_PAYLOAD_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  sptx_in_if.sink        pkt_in,
  output logic           push_valid,
  input  logic           push_ready,
  output sptx_pkg::job_t push_job
);

  logic       packet_open;
  logic [7:0] bytes_remaining;
  logic [7:0] running_sum;
  logic [7:0] held_flags;

  logic       accept;
  logic       too_long;
  logic [7:0] data_sum;
  logic [7:0] rem_dec;
  logic       data_tail;

  assign too_long  = pkt_in.payload_length > 8'(MAX_PAYLOAD);
  assign data_sum  = running_sum + pkt_in.data_byte;
  assign rem_dec   = bytes_remaining - 8'd1;
  assign data_tail = rem_dec == 8'd0;

  assign pkt_in.ready = push_ready;
  assign accept       = pkt_in.valid && push_ready;
  assign push_valid   = pkt_in.valid && (pkt_in.command == sptx_pkg::CMD_START || packet_open);

  always_comb begin
    push_job = '0;
    if (pkt_in.command == sptx_pkg::CMD_START) begin
      if (too_long) begin
        push_job.kind = sptx_pkg::JOB_ERR;
      end else begin
        push_job.kind  = sptx_pkg::JOB_START;
        push_job.body  = pkt_in.payload_length;
        push_job.tail  = pkt_in.payload_length == 8'd0;
        push_job.flags = pkt_in.flags_byte;
        push_job.sum   = pkt_in.payload_length + pkt_in.flags_byte;
      end
    end else begin
      push_job.kind  = sptx_pkg::JOB_DATA;
      push_job.body  = pkt_in.data_byte;
      push_job.tail  = data_tail;
      push_job.flags = held_flags;
      push_job.sum   = data_sum + held_flags;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_open     <= 1'b0;
      bytes_remaining <= '0;
      running_sum     <= '0;
      held_flags      <= '0;
    end else if (accept) begin
      if (pkt_in.command == sptx_pkg::CMD_START) begin
        if (!too_long) begin
          held_flags      <= pkt_in.flags_byte;
          running_sum     <= pkt_in.payload_length;
          bytes_remaining <= pkt_in.payload_length;
          packet_open     <= pkt_in.payload_length != 8'd0;
        end
      end else if (packet_open) begin
        running_sum     <= data_sum;
        bytes_remaining <= rem_dec;
        packet_open     <= !data_tail;
      end
    end
  end

endmodule

// File: rtl/sptx_queue.sv
// short job queue between the front and back parts
module sptx_queue #(
  parameter int DEPTH = sptx_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  sptx_pkg::job_t push_job,
  output logic           pop_valid,
  input  logic           pop_ready,
  output sptx_pkg::job_t pop_job
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  sptx_pkg::job_t mem [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  assign push_ready = count != CW'(DEPTH);
  assign pop_valid  = count != '0;
  assign pop_job    = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/sptx_back.sv
// back part: expands jobs into escaped line bytes through an output register
module sptx_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  sptx_pkg::job_t pop_job,
  sptx_out_if.source     line_out
);

  sptx_pkg::job_t   cur;
  logic             busy;
  sptx_pkg::phase_t phase;
  sptx_pkg::phase_t phase_next;
  logic             esc_pend;

  logic [7:0] raw;
  logic       escapable;
  logic       needs_esc;
  logic [7:0] gen_byte;
  logic       byte_done;
  logic       is_last;
  logic       can_emit;
  logic       emit;

  assign can_emit = !line_out.valid || line_out.ready;
  assign emit     = busy && can_emit;

  always_comb begin
    raw        = sptx_pkg::SLIP_END;
    escapable  = 1'b0;
    phase_next = phase;
    is_last    = 1'b0;
    unique case (phase)
      sptx_pkg::PH_ERR: begin
        raw     = 8'h00;
        is_last = 1'b1;
      end
      sptx_pkg::PH_END0: begin
        phase_next = sptx_pkg::PH_BODY;
      end
      sptx_pkg::PH_BODY: begin
        raw        = cur.body;
        escapable  = 1'b1;
        phase_next = sptx_pkg::PH_FLAGS;
        is_last    = !cur.tail;
      end
      sptx_pkg::PH_FLAGS: begin
        raw        = cur.flags;
        escapable  = 1'b1;
        phase_next = sptx_pkg::PH_SUM;
      end
      sptx_pkg::PH_SUM: begin
        raw        = cur.sum;
        escapable  = 1'b1;
        phase_next = sptx_pkg::PH_END1;
      end
      sptx_pkg::PH_END1: begin
        is_last = 1'b1;
      end
      default: begin
        is_last = 1'b1;
      end
    endcase
  end

  assign needs_esc = escapable && (raw == sptx_pkg::SLIP_END || raw == sptx_pkg::SLIP_ESC);
  assign byte_done = esc_pend || !needs_esc;

  always_comb begin
    if (esc_pend) begin
      gen_byte = (raw == sptx_pkg::SLIP_END) ? sptx_pkg::SLIP_ESC_END : sptx_pkg::SLIP_ESC_ESC;
    end else if (needs_esc) begin
      gen_byte = sptx_pkg::SLIP_ESC;
    end else begin
      gen_byte = raw;
    end
  end

  assign pop_ready = !busy || (emit && byte_done && is_last);

  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) begin
      cur <= pop_job;
    end
    if (emit) begin
      line_out.out_byte <= gen_byte;
      line_out.run_last <= byte_done && is_last;
      line_out.error    <= phase == sptx_pkg::PH_ERR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy           <= 1'b0;
      phase          <= sptx_pkg::PH_ERR;
      esc_pend       <= 1'b0;
      line_out.valid <= 1'b0;
    end else begin
      if (emit) begin
        line_out.valid <= 1'b1;
      end else if (line_out.ready) begin
        line_out.valid <= 1'b0;
      end

      if (pop_valid && pop_ready) begin
        busy     <= 1'b1;
        esc_pend <= 1'b0;
        unique case (pop_job.kind)
          sptx_pkg::JOB_ERR:   phase <= sptx_pkg::PH_ERR;
          sptx_pkg::JOB_START: phase <= sptx_pkg::PH_END0;
          sptx_pkg::JOB_DATA:  phase <= sptx_pkg::PH_BODY;
          default:             phase <= sptx_pkg::PH_ERR;
        endcase
      end else if (emit) begin
        esc_pend <= !byte_done;
        if (byte_done) begin
          phase <= phase_next;
        end
        if (byte_done && is_last) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

// File: rtl/slip_packet_framer_tx_core.sv
// top level of the slip packet framer transmit core
// SLIP transmit framer: a start item sends END and the escaped length byte, each data item
// sends its escaped payload byte, and after the last payload byte the escaped flags byte,
// the escaped 8-bit checksum and a closing END follow; an oversized start gives one error
// item. The line side moves one byte per cycle through a registered output when not stalled
// by line_out.ready. An input item yields a line byte count of none for a dropped data item,
// one for a plain payload byte, two for an escaped one and up to seven for a zero-length
// start or a closing payload byte. A job queue of QUEUE_DEPTH entries sits between the input
// side and the byte generator, so new items are taken while earlier ones are still going out.
module slip_packet_framer_tx_core #(
  parameter int MAX_PAYLOAD = sptx_pkg::MAX_PAYLOAD_DEFAULT,
  parameter int QUEUE_DEPTH = sptx_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  sptx_in_if.sink    pkt_in,
  sptx_out_if.source line_out
);

  logic           push_valid;
  logic           push_ready;
  sptx_pkg::job_t push_job;
  logic           pop_valid;
  logic           pop_ready;
  sptx_pkg::job_t pop_job;

  sptx_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .pkt_in     (pkt_in),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  sptx_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  sptx_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_job   (pop_job),
    .line_out  (line_out)
  );

endmodule

// File: rtl/sptx_checker.sv
// port-level assertions for the slip packet framer transmit core
module sptx_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       run_last,
  input logic       error
);

  a_error_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && error |-> out_byte == 8'h00 && run_last)
    else $error("error item malformed");

  a_last_not_esc: assert property (@(posedge clk) disable iff (rst)
    out_valid && run_last && !error |-> out_byte != sptx_pkg::SLIP_ESC)
    else $error("escape byte closes an item");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(run_last)
      && $stable(error))
    else $error("stalled output changed");

endmodule

bind slip_packet_framer_tx_core sptx_checker u_sptx_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (line_out.valid),
  .out_ready (line_out.ready),
  .out_byte  (line_out.out_byte),
  .run_last  (line_out.run_last),
  .error     (line_out.error)
);
